/* rtl/core/f32add_pkg.sv */
// Package for the truncating single-precision adder: field widths and masks.
// No dependencies.
package f32add_pkg;
    localparam int WordW = 32;
    localparam int ExpW  = 8;
    localparam int FracW = 23;
    localparam int MantW = 24;
    localparam int SumW  = 25;
    localparam int LzW   = 5;
    localparam logic [ExpW-1:0]  EXP_MASK  = 8'hFF;
    localparam logic [FracW-1:0] FRAC_MASK = 23'h7FFFFF;
endpackage

/* rtl/core/f32add_if.sv */
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing.
interface f32add_if #(parameter int W = 32) (input logic clk);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/float32_add_truncating.sv */
// Top level of the truncating single-precision adder.
// Depends on f32add_pkg and f32add_if.
//
// Usage: requests arrive on in_ch (data = {operand_b, operand_a}) and
// results leave on out_ch (data = sum_bits). A request is taken when
// valid and ready are both high at a rising edge of clk.
// A request passes the stage 1, 2 and 3 registers and out_reg before sum_bits shows on out_ch.
// Throughput: one request per cycle while out_ch.ready is high; four register stages
//   1 unpack, exponent compare, zero detection
//   2 alignment shift of the smaller mantissa
//   3 add or subtract, pick larger magnitude
//   4 leading-zero normalise and pack
// The rate does not depend on the stage depth and no loop holds it:
// every request passes each stage once.
// Reset (rst_n low, asynchronous) clears all stage valid bits; data
// registers are not reset.
// Stall: when out_ch.ready is low a full stage holds until the one after it is free; in_ch.ready
// falls only once every stage is full, so no request is lost or
// repeated, and bubbles are squeezed out while the sink waits.
module float32_add_truncating (
    input logic    clk,
    input logic    rst_n,
    f32add_if.sink   in_ch,
    f32add_if.source out_ch
);
    localparam int EW = f32add_pkg::ExpW;
    localparam int MW = f32add_pkg::MantW;
    localparam int SW = f32add_pkg::SumW;

    logic [3:0] v_reg;
    logic [3:0] adv;

    // advance per stage: a stage moves on when the one after is free
    always_comb
    begin
        adv[3] = !v_reg[3] || out_ch.ready;
        adv[2] = !v_reg[2] || adv[3];
        adv[1] = !v_reg[1] || adv[2];
        adv[0] = !v_reg[0] || adv[1];
    end
    assign in_ch.ready = adv[0];

    logic [31:0] opa, opb;
    assign opa = in_ch.data[31:0];
    assign opb = in_ch.data[63:32];

    // stage 1
    logic          s1_bypass_reg, s1_sa_reg, s1_sb_reg, s1_swap_reg;
    logic [31:0]   s1_byp_reg;
    logic [EW-1:0] s1_e_reg, s1_d_reg;
    logic          s1_big_reg;
    logic [MW-1:0] s1_ma_reg, s1_mb_reg;
    logic [EW-1:0] ea, eb;
    logic          a_lt;
    assign ea   = opa[30:23] & f32add_pkg::EXP_MASK;
    assign eb   = opb[30:23] & f32add_pkg::EXP_MASK;
    assign a_lt = ea < eb;

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            s1_bypass_reg <= (opa[30:0] == '0) || (opb[30:0] == '0);
            s1_byp_reg    <= (opa[30:0] == '0) ? opb : opa;
            s1_sa_reg     <= opa[31];
            s1_sb_reg     <= opb[31];
            s1_swap_reg   <= a_lt;
            s1_e_reg      <= a_lt ? eb : ea;
            s1_d_reg      <= a_lt ? (eb - ea) : (ea - eb);
            s1_big_reg    <= 1'b0;
            s1_ma_reg     <= {1'b1, opa[22:0] & f32add_pkg::FRAC_MASK};
            s1_mb_reg     <= {1'b1, opb[22:0] & f32add_pkg::FRAC_MASK};
        end
    end

    // stage 2: align (shift >= 24 already clears a 24-bit mantissa)
    logic          s2_bypass_reg, s2_sa_reg, s2_sb_reg;
    logic [31:0]   s2_byp_reg;
    logic [EW-1:0] s2_e_reg;
    logic [MW-1:0] s2_ma_reg, s2_mb_reg;
    logic [MW-1:0] sm;
    assign sm = (s1_d_reg >= 8'd32 || s1_big_reg) ? '0 :
                ((s1_swap_reg ? s1_ma_reg : s1_mb_reg) >> s1_d_reg[4:0]);

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            s2_bypass_reg <= s1_bypass_reg;
            s2_byp_reg    <= s1_byp_reg;
            s2_sa_reg     <= s1_sa_reg;
            s2_sb_reg     <= s1_sb_reg;
            s2_e_reg      <= s1_e_reg;
            s2_ma_reg     <= s1_swap_reg ? sm : s1_ma_reg;
            s2_mb_reg     <= s1_swap_reg ? s1_mb_reg : sm;
        end
    end

    // stage 3: add or subtract
    logic          s3_bypass_reg, s3_s_reg, s3_eff_sub_reg;
    logic [31:0]   s3_byp_reg;
    logic [EW-1:0] s3_e_reg;
    logic [SW-1:0] s3_m_reg;
    logic          a_gt;
    assign a_gt = s2_ma_reg > s2_mb_reg;

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            s3_bypass_reg  <= s2_bypass_reg;
            s3_byp_reg     <= s2_byp_reg;
            s3_e_reg       <= s2_e_reg;
            s3_eff_sub_reg <= s2_sa_reg != s2_sb_reg;
            if (s2_sa_reg == s2_sb_reg)
            begin
                s3_s_reg <= s2_sa_reg;
                s3_m_reg <= {1'b0, s2_ma_reg} + {1'b0, s2_mb_reg};
            end
            else
            begin
                s3_s_reg <= a_gt ? s2_sa_reg : s2_sb_reg;
                s3_m_reg <= a_gt ? {1'b0, s2_ma_reg - s2_mb_reg}
                                 : {1'b0, s2_mb_reg - s2_ma_reg};
            end
        end
    end

    // stage 4: normalise and pack
    logic [f32add_pkg::LzW-1:0] lz;
    logic [31:0]               res;
    always_comb
    begin
        lz = '0;
        for (int i = 0; i < MW; i++)
        begin
            if (s3_m_reg[i])
                lz = f32add_pkg::LzW'(MW - 1 - i);
        end
        if (s3_bypass_reg)
            res = s3_byp_reg;
        else if (!s3_eff_sub_reg)
        begin
            if (s3_m_reg[SW-1])
                res = {s3_s_reg, s3_e_reg + 8'd1, s3_m_reg[23:1]};
            else
                res = {s3_s_reg, s3_e_reg, s3_m_reg[22:0]};
        end
        else if (s3_m_reg == '0)
            res = '0;
        else
        begin
            res[31]    = s3_s_reg;
            res[30:23] = s3_e_reg - EW'(lz);
            res[22:0]  = s3_m_reg[22:0] << lz;
        end
    end

    logic [31:0] out_reg;
    always_ff @(posedge clk)
    begin
        if (adv[3])
            out_reg <= res;
    end
    assign out_ch.data  = out_reg;
    assign out_ch.valid = v_reg[3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (adv[0]) v_reg[0] <= in_ch.valid;
            if (adv[1]) v_reg[1] <= v_reg[0];
            if (adv[2]) v_reg[2] <= v_reg[1];
            if (adv[3]) v_reg[3] <= v_reg[2];
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[3] && !out_ch.ready |=> v_reg[3] && $stable(out_reg))
        else $error("result changed under stall");
    a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ch.ready |-> v_reg == 4'hF)
        else $error("input stalled with a free stage");
    a_norm: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[2] && !s3_bypass_reg && s3_eff_sub_reg && s3_m_reg != '0
        |-> s3_m_reg[SW-1] == 1'b0)
        else $error("subtract overflowed");
endmodule

/* bench/testbench.sv */
// Testbench for float32_add_truncating: directed table then random requests,
// checked against a local truncating-adder predictor. Depends on f32add_pkg, f32add_if.
module testbench;
    localparam int WordW = f32add_pkg::WordW;
    localparam int ExpW  = f32add_pkg::ExpW;
    localparam int FracW = f32add_pkg::FracW;

    logic clk;
    logic rst_n;

    f32add_if #(.W(2*WordW)) in_ch  (clk);
    f32add_if #(.W(WordW))   out_ch (clk);

    float32_add_truncating u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // One directed row: operands, and a typed-in sum where it is obvious.
    typedef struct {
        logic [WordW-1:0] a;
        logic [WordW-1:0] b;
        bit               known;
        logic [WordW-1:0] sum;
    } add_row_t;

    logic [WordW-1:0] sum_queue[$];
    int               fail_count;
    int               sent_count;
    int               got_count;
    int               long_hold;    // cycles left in the long sink hold-off
    bit               quiet;        // last part of the run: no idling
    bit               sending_done;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Generous ceiling for ~720 requests, even when stalled.
    initial
    begin
        #400000;
        $display("float32_add_truncating: mismatch");
        $finish;
    end

    // Truncating add of two single-precision patterns, no rounding, exponent wraps.
    function automatic logic [WordW-1:0] trunc_sum(logic [WordW-1:0] a,
                                                   logic [WordW-1:0] b);
        logic [ExpW-1:0]  ea;
        logic [ExpW-1:0]  eb;
        logic [ExpW-1:0]  ex;
        logic [31:0]      ma;
        logic [31:0]      mb;
        logic [31:0]      m;
        logic [31:0]      gap;
        logic             sgn;
        ea = a[30:23];
        eb = b[30:23];
        if (a[30:0] == '0)
            return b;
        if (b[30:0] == '0)
            return a;
        ma = {8'd0, 1'b1, a[FracW-1:0]};
        mb = {8'd0, 1'b1, b[FracW-1:0]};
        if (ea < eb)
        begin
            gap = eb - ea;
            ma  = (gap >= 32) ? '0 : ma >> gap;
            ex  = eb;
        end
        else
        begin
            gap = ea - eb;
            mb  = (gap >= 32) ? '0 : mb >> gap;
            ex  = ea;
        end
        if (a[31] == b[31])
        begin
            sgn = a[31];
            m   = ma + mb;
            if (m[24])
            begin
                m  = m >> 1;
                ex = ex + 1'b1;
            end
        end
        else
        begin
            // larger magnitude wins the sign; a tie goes to operand b
            sgn = (ma > mb) ? a[31] : b[31];
            m   = (ma > mb) ? ma - mb : mb - ma;
            if (m == 0)
                return '0;
            while (!m[23])
            begin
                m  = m << 1;
                ex = ex - 1'b1;
            end
        end
        return {sgn, ex, m[FracW-1:0]};
    endfunction

    // Random operand: mostly close exponents so the add/sub paths get exercised.
    function automatic logic [WordW-1:0] rand_operand(logic [ExpW-1:0] near);
        logic [WordW-1:0] v;
        v = $urandom;
        case ($urandom_range(0, 9))
            0: v[30:0] = '0;                         // signed zero
            1, 2: v = v;                             // anything at all
            default: v[30:23] = ExpW'(near + $urandom_range(0, 6) - 3);
        endcase
        return v;
    endfunction

    // Sender: may idle for a random gap first, then drives a request and holds it until accepted.
    task automatic send_request(logic [WordW-1:0] a, logic [WordW-1:0] b);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 7);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= {b, a};
        sum_queue.push_back(trunc_sum(a, b));
        sent_count++;
        do
            @(posedge clk);
        while (!in_ch.ready);
    endtask

    // Directed rows: zeros, extremes, cancellation, wide gaps, carry, wraps.
    add_row_t directed_rows[] = '{
        '{32'h0000_0000, 32'h0000_0000, 1, 32'h0000_0000},
        '{32'h8000_0000, 32'h8000_0000, 1, 32'h8000_0000},
        '{32'h0000_0000, 32'hDEAD_BEEF, 1, 32'hDEAD_BEEF},
        '{32'h8000_0000, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF},
        '{32'h1234_5678, 32'h8000_0000, 1, 32'h1234_5678},
        '{32'h3F80_0000, 32'hBF80_0000, 1, 32'h0000_0000},
        '{32'hFFFF_FFFF, 32'h7FFF_FFFF, 1, 32'h0000_0000},
        '{32'h3F80_0000, 32'h3F80_0000, 1, 32'h4000_0000},
        '{32'h7F80_0000, 32'h7F80_0000, 1, 32'h0000_0000},
        '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, '0},
        '{32'h0080_0000, 32'h8000_0001, 0, '0},
        '{32'h0000_0001, 32'h8000_0003, 0, '0},
        '{32'h7F80_0000, 32'h0000_0001, 0, '0},
        '{32'h4F80_0000, 32'h3F80_0000, 0, '0},
        '{32'h3F80_0000, 32'h4F80_0000, 0, '0},
        '{32'h3F80_0001, 32'hBF80_0000, 0, '0},
        '{32'h4000_0000, 32'hBFFF_FFFF, 0, '0},
        '{32'hAAAA_AAAA, 32'h5555_5555, 0, '0},
        '{32'h5555_5555, 32'hAAAA_AAAA, 0, '0},
        '{32'hC040_0000, 32'hC0A0_0000, 0, '0}
    };

    // Stimulus process.
    initial
    begin
        logic [ExpW-1:0] near;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        rst_n        = 1'b0;
        quiet        = 1'b0;
        sending_done = 1'b0;
        sent_count   = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            send_request(directed_rows[i].a, directed_rows[i].b);
            // the typed-in sum must also agree with the predictor
            if (directed_rows[i].known && sum_queue[$] !== directed_rows[i].sum)
            begin
                $error("sum_bits predictor row %0d: expected %h actual %h",
                       i, directed_rows[i].sum, sum_queue[$]);
                fail_count++;
            end
        end

        for (int n = 0; n < 700; n++)
        begin
            if (n == 600)
                quiet = 1'b1;
            near = ExpW'($urandom);
            send_request(rand_operand(near), rand_operand(near));
        end
        in_ch.valid  <= 1'b0;
        sending_done = 1'b1;
    end

    // Sink: random stall bursts, plus one long hold-off so the pipe fills and
    // pushes back on in_ch.ready while the sender keeps offering requests.
    initial
    begin
        int stall;
        out_ch.ready = 1'b0;
        long_hold    = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (got_count >= 200 && long_hold == 0)
                long_hold = 60;
            if (long_hold > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (long_hold) @(posedge clk);
                long_hold = -1;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                stall = $urandom_range(1, 7);
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
        end
    end

    // Checker: every accepted result against the oldest expected sum.
    initial
    begin
        logic [WordW-1:0] want;
        fail_count = 0;
        got_count  = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready)
            begin
                got_count++;
                if (sum_queue.size() == 0)
                begin
                    $error("sum_bits: unexpected result %h", out_ch.data);
                    fail_count++;
                end
                else
                begin
                    want = sum_queue.pop_front();
                    if (out_ch.data !== want)
                    begin
                        $error("sum_bits: expected %h actual %h", want, out_ch.data);
                        fail_count++;
                    end
                end
            end
        end
    end

    // End of run: drain, settle for the pipe depth, then report.
    initial
    begin
        wait (sending_done);
        wait (sum_queue.size() == 0);
        repeat (10) @(posedge clk);
        $display("Covered %0d requests (directed zeros, extremes, cancellation, wraps;",
                 sent_count);
        $display("random near-exponent add/sub) with sink stalls and a long hold-off.");
        if (fail_count == 0)
            $display("float32_add_truncating: match");
        else
            $display("float32_add_truncating: mismatch");
        $finish;
    end
endmodule

/* float32_add_truncating.f */
rtl/core/f32add_pkg.sv
rtl/core/f32add_if.sv
rtl/core/float32_add_truncating.sv
bench/testbench.sv
